[rtl/first_fit_heap_allocator_macros.svh]
// Assertion macros for the first-fit heap allocator.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffha assertion failed");
`define FFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffha assertion failed");
`else
`define FFHA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define FFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/ffha_pkg.sv]
// Shared types, codes and helpers of the first-fit heap allocator.
// No dependencies; used by ffha_ctrl, ffha_dpath and the top level.
package ffha_pkg;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_HEADER_BYTES = 12;
  localparam int DEF_WORD_BYTES   = 4;

  localparam int REM_W = 5;   // remainder of a division by up to 31
  localparam int MEM_W = 33;  // {free, size}

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_INIT    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_INIT  = 3'd1,
    ST_NO_MEM    = 3'd2,
    ST_NULL      = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_BAD_BOUND = 3'd5
  } status_t;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_RND, S_NEED, S_ARD, S_ACHK, S_UPRD, S_UPWR, S_SPL1, S_SPL2,
    S_RRD, S_RCHK, S_NRD, S_NCHK, S_DNRD, S_DNWR, S_PRD, S_PCHK, S_RWR, S_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    C_NOP, C_START, C_ROUND, C_NEED, C_SCAN_RD, C_A_CHK, C_UP_RD, C_UP_WR,
    C_SPLIT_HI, C_SPLIT_LO, C_R_CHK, C_NEXT_RD, C_N_CHK, C_DN_RD, C_DN_WR,
    C_DN_END, C_PREV_RD, C_P_CHK, C_R_WR, C_DONE
  } dp_cmd_t;

  typedef struct packed {
    logic ready;
    logic rel_zero;
    logic rnd_last;
    logic scan_end;
    logic hit;
    logic split;
    logic up_done;
    logic addr_match;
    logic rd_free;
    logic has_next;
    logic has_prev;
    logic dn_done;
  } ctl_status_t;

  // Four bits of a long division by wb, most significant first.
  function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] r,
                                                input logic [3:0] nib,
                                                input logic [REM_W-1:0] wb);
    logic [REM_W:0] t;
    logic [REM_W-1:0] acc;
    acc = r;
    for (int k = 3; k >= 0; k--) begin
      t = {acc, nib[k]};
      if (t >= {1'b0, wb}) begin
        t = t - {1'b0, wb};
      end
      acc = t[REM_W-1:0];
    end
    return acc;
  endfunction

endpackage

[rtl/ffha_ctrl.sv]
// Sequencer of the first-fit heap allocator: one state per datapath step.
// Depends on ffha_pkg; drives ffha_dpath through dp_cmd_t commands.
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  op,
  input  ctl_status_t st,
  output dp_cmd_t     cmd,
  output logic        busy
);

  ctl_state_t state, state_next;
  logic in_prev, in_prev_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_prev <= 1'b0;
    end else begin
      state   <= state_next;
      in_prev <= in_prev_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_prev_next = in_prev;
    unique case (state)
      S_IDLE: begin
        in_prev_next = 1'b0;
        if (start) begin
          if (op == OP_ALLOC) begin
            state_next = st.ready ? S_RND : S_DONE;
          end else if (op == OP_RELEASE) begin
            state_next = (!st.rel_zero && st.ready) ? S_RRD : S_DONE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RND:  state_next = st.rnd_last ? S_NEED : S_RND;
      S_NEED: state_next = S_ARD;
      S_ARD:  state_next = st.scan_end ? S_DONE : S_ACHK;
      S_ACHK: state_next = st.hit ? (st.split ? S_UPRD : S_DONE) : S_ARD;
      S_UPRD: state_next = st.up_done ? S_SPL1 : S_UPWR;
      S_UPWR: state_next = S_UPRD;
      S_SPL1: state_next = S_SPL2;
      S_SPL2: state_next = S_DONE;
      S_RRD:  state_next = st.scan_end ? S_DONE : S_RCHK;
      S_RCHK: state_next = st.addr_match ? (st.rd_free ? S_DONE : S_NRD) : S_RRD;
      S_NRD:  state_next = st.has_next ? S_NCHK : S_PRD;
      S_NCHK: state_next = st.rd_free ? S_DNRD : S_PRD;
      S_DNRD: state_next = st.dn_done ? (in_prev ? S_DONE : S_PRD) : S_DNWR;
      S_DNWR: state_next = S_DNRD;
      S_PRD:  state_next = st.has_prev ? S_PCHK : S_RWR;
      S_PCHK: begin
        if (st.rd_free) begin
          state_next   = S_DNRD;
          in_prev_next = 1'b1;
        end else begin
          state_next = S_RWR;
        end
      end
      S_RWR:  state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: cmd = start ? C_START : C_NOP;
      S_RND:  cmd = C_ROUND;
      S_NEED: cmd = C_NEED;
      S_ARD:  cmd = C_SCAN_RD;
      S_ACHK: cmd = C_A_CHK;
      S_UPRD: cmd = st.up_done ? C_NOP : C_UP_RD;
      S_UPWR: cmd = C_UP_WR;
      S_SPL1: cmd = C_SPLIT_HI;
      S_SPL2: cmd = C_SPLIT_LO;
      S_RRD:  cmd = C_SCAN_RD;
      S_RCHK: cmd = C_R_CHK;
      S_NRD:  cmd = C_NEXT_RD;
      S_NCHK: cmd = C_N_CHK;
      S_DNRD: cmd = st.dn_done ? C_DN_END : C_DN_RD;
      S_DNWR: cmd = C_DN_WR;
      S_PRD:  cmd = C_PREV_RD;
      S_PCHK: cmd = C_P_CHK;
      S_RWR:  cmd = C_R_WR;
      S_DONE: cmd = C_DONE;
      default: cmd = C_NOP;
    endcase
  end

endmodule

[rtl/ffha_dpath.sv]
// Datapath of the first-fit heap allocator: segment memory, scan pointers,
// address accumulator, size rounding and result registers. Uses ffha_pkg.
module ffha_dpath
  import ffha_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int WORD_BYTES   = DEF_WORD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output ctl_status_t st,
  input  logic [1:0]  op,
  input  logic [31:0] request_bytes,
  input  logic [31:0] release_address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] payload_address,
  output logic [2:0]  status
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);
  localparam logic [REM_W-1:0] WB = REM_W'(WORD_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  logic [MEM_W-1:0] mem [MAX_SEGMENTS];

  logic [31:0]      heap_base, heap_limit;
  logic             ready;
  logic [CW-1:0]    cnt, ptr;
  logic [IW-1:0]    sel;
  logic [31:0]      run_addr, rel, req, sz;
  logic [REM_W-1:0] rem;
  logic [2:0]       rcnt;
  logic [32:0]      need;
  logic [33:0]      need_h;
  logic [1:0]       op_q;
  logic [MEM_W-1:0] rd_q;
  logic [31:0]      res_addr;
  logic [2:0]       res_status;

  logic             bounds_ok;
  logic [32:0]      need_w;
  logic [31:0]      rd_size;
  logic [CW-1:0]    sel_c, sel_p1;
  logic             mem_we, mem_re;
  logic [IW-1:0]    wr_idx, rd_idx;
  logic [MEM_W-1:0] wr_data;

  assign rd_size   = rd_q[31:0];
  assign sel_c     = CW'(sel);
  assign sel_p1    = sel_c + CW'(1);
  assign bounds_ok = (heap_base != 32'd0) && (heap_limit != 32'd0) &&
                     (heap_limit >= heap_base) && ((heap_limit - heap_base) >= HDR);
  assign need_w    = {1'b0, req} + ((rem == '0) ? 33'd0 : 33'(WB - rem));

  always_comb begin
    st.ready      = ready;
    st.rel_zero   = (release_address == 32'd0);
    st.rnd_last   = (rcnt == 3'd7);
    st.scan_end   = (ptr == cnt);
    st.hit        = rd_q[32] && ({1'b0, rd_size} >= need);
    st.split      = ({2'b00, rd_size} > need_h) && (cnt < MAXC);
    st.up_done    = (ptr == sel_p1);
    st.addr_match = (run_addr == rel);
    st.rd_free    = rd_q[32];
    st.has_next   = (sel_p1 < cnt);
    st.has_prev   = (sel != '0);
    st.dn_done    = ({1'b0, ptr} + (CW+1)'(1)) >= {1'b0, cnt};
  end

  // memory port steering
  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    wr_idx  = ptr[IW-1:0];
    rd_idx  = ptr[IW-1:0];
    wr_data = rd_q;
    unique case (cmd)
      C_START: begin
        mem_we  = (op == OP_INIT) && bounds_ok;
        wr_idx  = '0;
        wr_data = {1'b1, heap_limit - heap_base - HDR};
      end
      C_A_CHK: begin
        mem_we  = st.hit && !st.split;
        wr_data = {1'b0, rd_size};
      end
      C_UP_WR:    mem_we = 1'b1;
      C_DN_WR:    mem_we = 1'b1;
      C_SPLIT_HI: begin
        mem_we  = 1'b1;
        wr_idx  = sel_p1[IW-1:0];
        wr_data = {1'b1, sz - need[31:0] - HDR};
      end
      C_SPLIT_LO: begin
        mem_we  = 1'b1;
        wr_idx  = sel;
        wr_data = {1'b0, need[31:0]};
      end
      C_P_CHK: begin
        mem_we  = rd_q[32];
        wr_idx  = sel - IW'(1);
        wr_data = {1'b1, rd_size + HDR + sz};
      end
      C_R_WR: begin
        mem_we  = 1'b1;
        wr_idx  = sel;
        wr_data = {1'b1, sz};
      end
      C_SCAN_RD: mem_re = 1'b1;
      C_UP_RD: begin
        mem_re = 1'b1;
        rd_idx = IW'(ptr - CW'(1));
      end
      C_NEXT_RD: begin
        mem_re = 1'b1;
        rd_idx = sel_p1[IW-1:0];
      end
      C_DN_RD: begin
        mem_re = 1'b1;
        rd_idx = IW'(ptr + CW'(1));
      end
      C_PREV_RD: begin
        mem_re = 1'b1;
        rd_idx = sel - IW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= mem[rd_idx];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= 32'd0;
      heap_limit <= 32'd0;
      ready      <= 1'b0;
      cnt        <= '0;
      done       <= 1'b0;
    end else begin
      done <= (cmd == C_DONE);
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else begin
          heap_limit <= cfg_data;
        end
      end
      if (cmd == C_START && op == OP_INIT) begin
        ready <= bounds_ok;
        cnt   <= bounds_ok ? CW'(1) : '0;
      end else if (cmd == C_SPLIT_LO) begin
        cnt <= cnt + CW'(1);
      end else if (cmd == C_DN_END) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      C_START: begin
        op_q     <= op;
        req      <= request_bytes;
        rel      <= release_address;
        rem      <= '0;
        rcnt     <= 3'd0;
        ptr      <= '0;
        run_addr <= heap_base + HDR;
        res_addr <= 32'd0;
        if (op == OP_ALLOC) begin
          res_status <= ready ? ST_OK : ST_NOT_INIT;
        end else if (op == OP_RELEASE) begin
          res_status <= (release_address == 32'd0) ? ST_NULL :
                        (ready ? ST_OK : ST_NOT_INIT);
        end else if (op == OP_INIT) begin
          res_status <= bounds_ok ? ST_OK : ST_BAD_BOUND;
        end else begin
          res_status <= ST_OK;
        end
      end
      C_ROUND: begin
        rem  <= rem_step(rem, req[{~rcnt, 2'b00} +: 4], WB);
        rcnt <= rcnt + 3'd1;
      end
      C_NEED: need <= need_w;
      C_SCAN_RD: begin
        need_h <= {1'b0, need} + 34'(HDR);
        if (ptr == cnt) begin
          res_status <= (op_q == OP_ALLOC) ? ST_NO_MEM : ST_UNKNOWN;
        end
      end
      C_A_CHK: begin
        if (st.hit) begin
          sel      <= ptr[IW-1:0];
          sz       <= rd_size;
          res_addr <= run_addr;
          if (st.split) begin
            ptr <= cnt;
          end
        end else begin
          run_addr <= run_addr + HDR + rd_size;
          ptr      <= ptr + CW'(1);
        end
      end
      C_UP_WR: ptr <= ptr - CW'(1);
      C_R_CHK: begin
        if (st.addr_match) begin
          sel <= ptr[IW-1:0];
          sz  <= rd_size;
          if (rd_q[32]) begin
            res_status <= ST_UNKNOWN;
          end
        end else begin
          run_addr <= run_addr + HDR + rd_size;
          ptr      <= ptr + CW'(1);
        end
      end
      C_N_CHK: begin
        if (rd_q[32]) begin
          sz  <= sz + HDR + rd_size;
          ptr <= sel_p1;
        end
      end
      C_DN_WR: ptr <= ptr + CW'(1);
      C_P_CHK: ptr <= sel_c;
      default: ;
    endcase
  end

  assign payload_address = res_addr;
  assign status          = res_status;

endmodule

[rtl/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator with split and coalesce.
// Uses ffha_pkg, ffha_ctrl, ffha_dpath and first_fit_heap_allocator_macros.svh.
//
//  channel   | handshake         | payload
//  ----------+-------------------+--------------------------------------------
//  command   | start / busy      | op, request_bytes, release_address
//  result    | done (1 cycle)    | payload_address, status
//  config    | cfg_we            | cfg_index (0 heap_base, 1 heap_limit), cfg_data
//
// An item is taken when start is high and busy is low; its result shows with
// done for exactly one cycle, in which the next item may already be taken.
// Allocate rounds the request one nibble a cycle, then scans the segments and
// may split the chosen one; release scans for the address and may merge the
// segment with free neighbours. Init, no-op and rejected ops go straight to
// done. The segment memory is single-port, with one access per step.
// Reset (rst, synchronous) clears the heap bounds, the heap-ready flag, the
// segment count and done; the segment memory and the result registers are
// not cleared. The receiver cannot stall.
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int WORD_BYTES   = DEF_WORD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] request_bytes,
  input  logic [31:0] release_address,
  output logic        done,
  output logic [31:0] payload_address,
  output logic [2:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // command from the sequencer, flags back from the datapath
  dp_cmd_t     cmd;
  ctl_status_t st;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffha_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .HEADER_BYTES (HEADER_BYTES),
    .WORD_BYTES   (WORD_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .op              (op),
    .request_bytes   (request_bytes),
    .release_address (release_address),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .payload_address (payload_address),
    .status          (status)
  );

  // an accepted item makes the block busy from the next cycle
  `FFHA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // a result only appears once the item's work is over
  `FFHA_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // one result per item: the done strobe never repeats back to back
  `FFHA_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  // only a successful allocate hands out an address
  `FFHA_ASSERT_SAME(a_addr_zero, clk, rst, done && (status != ST_OK),
                    payload_address == 32'd0)

endmodule
